@@ hdl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the barometer compensation pipeline
// Widths of every intermediate value, calibration register indexes and the
// records that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int RAW_W    = 24;   // raw conversion results
    localparam int CAL_W    = 16;   // calibration words
    localparam int DT_W     = 25;   // temperature difference
    localparam int MUL_W    = 41;   // dT times a calibration word
    localparam int TEMP_W   = 19;   // temperature in 0.01 C
    localparam int OFF_W    = 36;   // first-order offset
    localparam int SENS_W   = 35;   // first-order sensitivity
    localparam int SQ_W     = 35;   // squared temperature distances
    localparam int CORR_W   = 38;   // second-order corrections
    localparam int OFFC_W   = 40;   // corrected offset
    localparam int SENSC_W  = 40;   // corrected sensitivity
    localparam int SPLIT_W  = 20;   // low slice of sensitivity in the split multiply
    localparam int PPLO_W   = RAW_W + SPLIT_W;
    localparam int PPHI_W   = RAW_W + 1 + SENSC_W - SPLIT_W;
    localparam int PROD_W   = 64;   // raw pressure times sensitivity
    localparam int Q_W      = 44;   // scaled product minus offset
    localparam int PRES_W   = 21;   // pressure in Pa
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_SENSITIVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_OFFSET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY_TEMP_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMP_COEFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_TEMPERATURE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_COEFF      = 3'd5;

    localparam logic signed [TEMP_W-1:0] TEMP_20C  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_M15C = -19'sd1500;

    localparam logic signed [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};
    localparam logic signed [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_coeff;
    } t_bpc_cal;

    // First-order results.
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [RAW_W-1:0]         raw_p;
    } t_bpc_fo;

    // Offset and sensitivity after the low-temperature correction.
    typedef struct packed {
        logic signed [TEMP_W-1:0]  temp;
        logic signed [OFFC_W-1:0]  off;
        logic signed [SENSC_W-1:0] sens;
        logic [RAW_W-1:0]          raw_p;
    } t_bpc_so;

endpackage

@@ hdl/bpc_in_if.sv @@
// ----------------------------------------------------------------------------
// bpc_in_if: raw conversion channel
// Carries one raw temperature and one raw pressure conversion per transaction.
// ----------------------------------------------------------------------------
interface bpc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bpc_pkg::RAW_W-1:0]  raw_temperature;
    logic [bpc_pkg::RAW_W-1:0]  raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

@@ hdl/bpc_out_if.sv @@
// ----------------------------------------------------------------------------
// bpc_out_if: compensated result channel
// Carries temperature in 0.01 C and pressure in Pa per transaction.
// ----------------------------------------------------------------------------
interface bpc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bpc_pkg::TEMP_W-1:0]  temperature_centi;
    logic signed [bpc_pkg::PRES_W-1:0]  pressure_pa;

    modport source (output valid, output temperature_centi, output pressure_pa, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_pa, output ready);
endinterface

@@ hdl/bpc_first_order.sv @@
// ----------------------------------------------------------------------------
// bpc_first_order: temperature difference, temperature, offset, sensitivity
// Three register stages: subtract, three parallel multiplies, scale and add.
// ----------------------------------------------------------------------------
module bpc_first_order (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [bpc_pkg::RAW_W-1:0]   i_raw_t,
    input  logic [bpc_pkg::RAW_W-1:0]   i_raw_p,
    input  bpc_pkg::t_bpc_cal           i_cal,
    output logic                        o_valid,
    output bpc_pkg::t_bpc_fo            o_data
);

    logic                               r1_v, r2_v, r3_v;
    logic signed [bpc_pkg::DT_W-1:0]    r1_dt;
    logic [bpc_pkg::RAW_W-1:0]          r1_raw_p, r2_raw_p;
    logic signed [bpc_pkg::MUL_W-1:0]   r2_pt, r2_po, r2_ps;
    bpc_pkg::t_bpc_fo                   r3_data;
    bpc_pkg::t_bpc_fo                   n_data;

    always_comb begin
        n_data.temp  = bpc_pkg::TEMP_20C + bpc_pkg::TEMP_W'(r2_pt >>> 23);
        n_data.off   = $signed({4'b0, i_cal.pressure_offset, 16'd0})
                       + bpc_pkg::OFF_W'(r2_po >>> 7);
        n_data.sens  = $signed({4'b0, i_cal.pressure_sensitivity, 15'd0})
                       + bpc_pkg::SENS_W'(r2_ps >>> 8);
        n_data.raw_p = r2_raw_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dt    <= $signed({1'b0, i_raw_t})
                        - $signed({1'b0, i_cal.reference_temperature, 8'd0});
            r1_raw_p <= i_raw_p;
            r2_pt    <= bpc_pkg::MUL_W'(r1_dt)
                        * $signed(bpc_pkg::MUL_W'(i_cal.temperature_coeff));
            r2_po    <= bpc_pkg::MUL_W'(r1_dt)
                        * $signed(bpc_pkg::MUL_W'(i_cal.offset_temp_coeff));
            r2_ps    <= bpc_pkg::MUL_W'(r1_dt)
                        * $signed(bpc_pkg::MUL_W'(i_cal.sensitivity_temp_coeff));
            r2_raw_p <= r1_raw_p;
            r3_data  <= n_data;
        end
    end

    assign o_valid = r3_v;
    assign o_data  = r3_data;

endmodule

@@ hdl/bpc_second_order.sv @@
// ----------------------------------------------------------------------------
// bpc_second_order: low-temperature correction of offset and sensitivity
// Three register stages: squares and band flags, corrections, subtraction.
// ----------------------------------------------------------------------------
module bpc_second_order (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  bpc_pkg::t_bpc_fo    i_data,
    output logic                o_valid,
    output bpc_pkg::t_bpc_so    o_data
);

    logic                                   r4_v, r5_v, r6_v;
    bpc_pkg::t_bpc_fo                       r4_data, r5_data;
    logic [bpc_pkg::SQ_W-1:0]               r4_d1, r4_d2;
    logic                                   r4_lt20, r4_lt15;
    logic [bpc_pkg::CORR_W-1:0]             r5_off2, r5_sens2;
    bpc_pkg::t_bpc_so                       r6_data;

    logic signed [bpc_pkg::TEMP_W-1:0]      x1, x2;
    logic signed [2*bpc_pkg::TEMP_W-1:0]    sq1, sq2;
    logic [bpc_pkg::CORR_W-1:0]             d1w, d2w, five_d1, seven_d2, eleven_d2;
    logic [bpc_pkg::CORR_W-1:0]             n_off2, n_sens2;
    bpc_pkg::t_bpc_so                       n_data;

    always_comb begin
        x1 = i_data.temp - bpc_pkg::TEMP_20C;
        x2 = i_data.temp - bpc_pkg::TEMP_M15C;
        sq1 = (2*bpc_pkg::TEMP_W)'(x1) * (2*bpc_pkg::TEMP_W)'(x1);
        sq2 = (2*bpc_pkg::TEMP_W)'(x2) * (2*bpc_pkg::TEMP_W)'(x2);
    end

    // The squares are non-negative, so plain shifts give the floor.
    always_comb begin
        d1w       = bpc_pkg::CORR_W'(r4_d1);
        d2w       = bpc_pkg::CORR_W'(r4_d2);
        five_d1   = (d1w << 2) + d1w;
        seven_d2  = (d2w << 3) - d2w;
        eleven_d2 = (d2w << 3) + (d2w << 1) + d2w;
        n_off2  = '0;
        n_sens2 = '0;
        if (r4_lt20) begin
            n_off2  = (five_d1 >> 1) + (r4_lt15 ? seven_d2 : '0);
            n_sens2 = (five_d1 >> 2) + (r4_lt15 ? (eleven_d2 >> 1) : '0);
        end
    end

    always_comb begin
        n_data.temp  = r5_data.temp;
        n_data.off   = bpc_pkg::OFFC_W'(r5_data.off) - $signed({2'b0, r5_off2});
        n_data.sens  = bpc_pkg::SENSC_W'(r5_data.sens) - $signed({2'b0, r5_sens2});
        n_data.raw_p = r5_data.raw_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= i_valid;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_data  <= i_data;
            r4_d1    <= bpc_pkg::SQ_W'(sq1);
            r4_d2    <= bpc_pkg::SQ_W'(sq2);
            r4_lt20  <= i_data.temp < bpc_pkg::TEMP_20C;
            r4_lt15  <= i_data.temp < bpc_pkg::TEMP_M15C;
            r5_data  <= r4_data;
            r5_off2  <= n_off2;
            r5_sens2 <= n_sens2;
            r6_data  <= n_data;
        end
    end

    assign o_valid = r6_v;
    assign o_data  = r6_data;

endmodule

@@ hdl/bpc_pressure.sv @@
// ----------------------------------------------------------------------------
// bpc_pressure: pressure from raw pressure, sensitivity and offset
// The 24 x 40 bit product is formed from two partial products, summed, scaled,
// offset, scaled again and saturated into the output register.
// ----------------------------------------------------------------------------
module bpc_pressure (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  bpc_pkg::t_bpc_so                    i_data,
    output logic                                o_valid,
    output logic signed [bpc_pkg::TEMP_W-1:0]   o_temp,
    output logic signed [bpc_pkg::PRES_W-1:0]   o_pres
);

    logic                                       r7_v, r8_v, r9_v, r10_v;
    logic [bpc_pkg::PPLO_W-1:0]                 r7_lo;
    logic signed [bpc_pkg::PPHI_W-1:0]          r7_hi;
    logic signed [bpc_pkg::PROD_W-1:0]          r8_prod;
    logic signed [bpc_pkg::Q_W-1:0]             r9_q;
    logic signed [bpc_pkg::OFFC_W-1:0]          r7_off, r8_off;
    logic signed [bpc_pkg::TEMP_W-1:0]          r7_temp, r8_temp, r9_temp, r10_temp;
    logic signed [bpc_pkg::PRES_W-1:0]          r10_pres;

    logic signed [bpc_pkg::Q_W-1:0]             p;
    logic [bpc_pkg::Q_W-bpc_pkg::PRES_W:0]      p_top;
    logic signed [bpc_pkg::PRES_W-1:0]          n_pres;

    // Saturate when the bits above the field are not a plain sign extension.
    always_comb begin
        p     = r9_q >>> 15;
        p_top = p[bpc_pkg::Q_W-1:bpc_pkg::PRES_W-1];
        if ((&p_top) || !(|p_top)) begin
            n_pres = p[bpc_pkg::PRES_W-1:0];
        end else if (p[bpc_pkg::Q_W-1]) begin
            n_pres = bpc_pkg::PRES_MIN;
        end else begin
            n_pres = bpc_pkg::PRES_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
        end else if (i_en) begin
            r7_v  <= i_valid;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_lo    <= bpc_pkg::PPLO_W'(i_data.raw_p)
                        * bpc_pkg::PPLO_W'(i_data.sens[bpc_pkg::SPLIT_W-1:0]);
            r7_hi    <= bpc_pkg::PPHI_W'($signed({1'b0, i_data.raw_p}))
                        * bpc_pkg::PPHI_W'($signed(
                              i_data.sens[bpc_pkg::SENSC_W-1:bpc_pkg::SPLIT_W]));
            r7_off   <= i_data.off;
            r7_temp  <= i_data.temp;
            r8_prod  <= (bpc_pkg::PROD_W'(r7_hi) <<< bpc_pkg::SPLIT_W)
                        + $signed({{(bpc_pkg::PROD_W-bpc_pkg::PPLO_W){1'b0}}, r7_lo});
            r8_off   <= r7_off;
            r8_temp  <= r7_temp;
            r9_q     <= bpc_pkg::Q_W'(r8_prod >>> 21) - bpc_pkg::Q_W'(r8_off);
            r9_temp  <= r8_temp;
            r10_pres <= n_pres;
            r10_temp <= r9_temp;
        end
    end

    assign o_valid = r10_v;
    assign o_temp  = r10_temp;
    assign o_pres  = r10_pres;

endmodule

@@ hdl/barometric_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: barometer temperature and pressure
// Throughput: one transaction per cycle; the ten-stage pipeline advances as a
// whole whenever the output register is empty or its result is taken.
// Reset: synchronous, active low; clears all valid bits and the six
// calibration registers.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bpc_in_if.sink                          i_in,
    bpc_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bpc_pkg::CAL_W-1:0]       i_cfg_data
);

    bpc_pkg::t_bpc_cal  r_cal;
    logic               en;
    logic               fo_valid, so_valid, out_valid;
    bpc_pkg::t_bpc_fo   fo_data;
    bpc_pkg::t_bpc_so   so_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpc_pkg::CFG_PRESSURE_SENSITIVITY:   r_cal.pressure_sensitivity   <= i_cfg_data;
                bpc_pkg::CFG_PRESSURE_OFFSET:        r_cal.pressure_offset        <= i_cfg_data;
                bpc_pkg::CFG_SENSITIVITY_TEMP_COEFF: r_cal.sensitivity_temp_coeff <= i_cfg_data;
                bpc_pkg::CFG_OFFSET_TEMP_COEFF:      r_cal.offset_temp_coeff      <= i_cfg_data;
                bpc_pkg::CFG_REFERENCE_TEMPERATURE:  r_cal.reference_temperature  <= i_cfg_data;
                bpc_pkg::CFG_TEMPERATURE_COEFF:      r_cal.temperature_coeff      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline stalls only while a finished result waits.
    assign en         = !out_valid || o_out.ready;
    assign i_in.ready = en;

    bpc_first_order u_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_raw_t (i_in.raw_temperature),
        .i_raw_p (i_in.raw_pressure),
        .i_cal   (r_cal),
        .o_valid (fo_valid),
        .o_data  (fo_data)
    );

    bpc_second_order u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fo_valid),
        .i_data  (fo_data),
        .o_valid (so_valid),
        .o_data  (so_data)
    );

    bpc_pressure u_pressure (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (so_valid),
        .i_data  (so_data),
        .o_valid (out_valid),
        .o_temp  (o_out.temperature_centi),
        .o_pres  (o_out.pressure_pa)
    );

    assign o_out.valid = out_valid;

endmodule

@@ sim/barometric_pressure_compensation_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_test: self-checking bench
// Feeds raw conversions through the pipeline under several calibration sets
// and compares each result with a behavioral calculation of the compensation.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_test;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 80;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int BLOCK_ITEMS    = 138;

    // Indexes past the last calibration word; writes to them must be ignored.
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Typical factory calibration and conversions.
    localparam logic [bpc_pkg::CAL_W-1:0] TYP_C1 = 16'd40127;
    localparam logic [bpc_pkg::CAL_W-1:0] TYP_C2 = 16'd36924;
    localparam logic [bpc_pkg::CAL_W-1:0] TYP_C3 = 16'd23317;
    localparam logic [bpc_pkg::CAL_W-1:0] TYP_C4 = 16'd23282;
    localparam logic [bpc_pkg::CAL_W-1:0] TYP_C5 = 16'd33464;
    localparam logic [bpc_pkg::CAL_W-1:0] TYP_C6 = 16'd28312;
    localparam logic [bpc_pkg::RAW_W-1:0] TYP_D1 = 24'd9085466;
    localparam logic [bpc_pkg::RAW_W-1:0] TYP_D2 = 24'd8569150;
    localparam logic [bpc_pkg::RAW_W-1:0] RAW_MAX = {bpc_pkg::RAW_W{1'b1}};

    typedef struct packed {
        logic [bpc_pkg::RAW_W-1:0] raw_t;
        logic [bpc_pkg::RAW_W-1:0] raw_p;
    } t_conversion;

    typedef struct packed {
        logic signed [bpc_pkg::TEMP_W-1:0] temp;
        logic signed [bpc_pkg::PRES_W-1:0] pres;
    } t_reading;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [bpc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bpc_pkg::CAL_W-1:0]     i_cfg_data;

    bpc_in_if  in_ch ();
    bpc_out_if out_ch ();

    barometric_pressure_compensation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    bpc_pkg::t_bpc_cal cal_model;
    t_conversion       pending_conversions[$];
    t_reading          expected_readings[$];
    int                queued_total;
    int                results_seen;
    int                error_count;
    int                idle_cycles;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                stall_req;
    int                stall_ack;
    int                hold_left;
    bit                in_fire;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Compensated temperature and pressure for one conversion pair under the
    // current calibration words.
    function automatic t_reading compensate(input logic [bpc_pkg::RAW_W-1:0] raw_t,
                                            input logic [bpc_pkg::RAW_W-1:0] raw_p);
        longint   dt, off, sens, temp, off2, sens2, sq, p;
        t_reading r;
        dt   = longint'(raw_t) - (longint'(cal_model.reference_temperature) << 8);
        off  = (longint'(cal_model.pressure_offset) << 16)
             + ((dt * longint'(cal_model.offset_temp_coeff)) >>> 7);
        sens = (longint'(cal_model.pressure_sensitivity) << 15)
             + ((dt * longint'(cal_model.sensitivity_temp_coeff)) >>> 8);
        temp = 2000 + ((dt * longint'(cal_model.temperature_coeff)) >>> 23);
        off2  = 0;
        sens2 = 0;
        if (temp < 2000) begin
            sq    = (temp - 2000) * (temp - 2000);
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (temp < -1500) begin
                sq    = (temp + 1500) * (temp + 1500);
                off2  = off2 + 7 * sq;
                sens2 = sens2 + ((11 * sq) >>> 1);
            end
        end
        off  = off - off2;
        sens = sens - sens2;
        p = (((longint'(raw_p) * sens) >>> 21) - off) >>> 15;
        if (p > longint'(bpc_pkg::PRES_MAX))
            p = longint'(bpc_pkg::PRES_MAX);
        if (p < longint'(bpc_pkg::PRES_MIN))
            p = longint'(bpc_pkg::PRES_MIN);
        r.temp = temp[bpc_pkg::TEMP_W-1:0];
        r.pres = p[bpc_pkg::PRES_W-1:0];
        return r;
    endfunction

    task automatic queue_conversion(input logic [bpc_pkg::RAW_W-1:0] raw_t,
                                    input logic [bpc_pkg::RAW_W-1:0] raw_p);
        t_conversion c;
        c.raw_t = raw_t;
        c.raw_p = raw_p;
        pending_conversions.push_back(c);
        queued_total++;
    endtask

    task automatic queue_random(input int count);
        logic [bpc_pkg::RAW_W-1:0] t;
        logic [bpc_pkg::RAW_W-1:0] p;
        logic [bpc_pkg::RAW_W-1:0] centre;
        logic [19:0]               jitter;
        repeat (count) begin
            centre = {cal_model.reference_temperature, 8'd0};
            jitter = 20'($urandom);
            t = bpc_pkg::RAW_W'($urandom);
            p = bpc_pkg::RAW_W'($urandom);
            case ($urandom_range(9))
                4, 5, 6: t = centre + {{(bpc_pkg::RAW_W-20){jitter[19]}}, jitter};
                7: t = $urandom_range(1) ? bpc_pkg::RAW_W'($urandom_range(255))
                                         : ~bpc_pkg::RAW_W'($urandom_range(255));
                8: p = $urandom_range(1) ? bpc_pkg::RAW_W'($urandom_range(255))
                                         : ~bpc_pkg::RAW_W'($urandom_range(255));
                9: begin
                    t = $urandom_range(1) ? '0 : RAW_MAX;
                    p = $urandom_range(1) ? '0 : RAW_MAX;
                end
                default: ;
            endcase
            queue_conversion(t, p);
        end
    endtask

    task automatic write_cal(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpc_pkg::CAL_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            bpc_pkg::CFG_PRESSURE_SENSITIVITY:   cal_model.pressure_sensitivity   = val;
            bpc_pkg::CFG_PRESSURE_OFFSET:        cal_model.pressure_offset        = val;
            bpc_pkg::CFG_SENSITIVITY_TEMP_COEFF: cal_model.sensitivity_temp_coeff = val;
            bpc_pkg::CFG_OFFSET_TEMP_COEFF:      cal_model.offset_temp_coeff      = val;
            bpc_pkg::CFG_REFERENCE_TEMPERATURE:  cal_model.reference_temperature  = val;
            bpc_pkg::CFG_TEMPERATURE_COEFF:      cal_model.temperature_coeff      = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_calibration(input bpc_pkg::t_bpc_cal c);
        write_cal(bpc_pkg::CFG_PRESSURE_SENSITIVITY,   c.pressure_sensitivity);
        write_cal(bpc_pkg::CFG_PRESSURE_OFFSET,        c.pressure_offset);
        write_cal(bpc_pkg::CFG_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
        write_cal(bpc_pkg::CFG_OFFSET_TEMP_COEFF,      c.offset_temp_coeff);
        write_cal(bpc_pkg::CFG_REFERENCE_TEMPERATURE,  c.reference_temperature);
        write_cal(bpc_pkg::CFG_TEMPERATURE_COEFF,      c.temperature_coeff);
        write_cal(CFG_SPARE_LO, bpc_pkg::CAL_W'($urandom));
        write_cal(CFG_SPARE_HI, bpc_pkg::CAL_W'($urandom));
    endtask

    function automatic logic [bpc_pkg::CAL_W-1:0] cal_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return {bpc_pkg::CAL_W{1'b1}};
            default: return bpc_pkg::CAL_W'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (results_seen < queued_total)
            @(negedge i_clk);
    endtask

    // Input driver: a new transaction is offered only once the previous one
    // has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (pending_conversions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid           <= 1'b1;
                in_ch.raw_temperature <= pending_conversions[0].raw_t;
                in_ch.raw_pressure    <= pending_conversions[0].raw_p;
                void'(pending_conversions.pop_front());
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver, with an occasional long hold-off to back up the pipeline.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
        end else if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (stall_ack != stall_req) begin
            stall_ack = stall_req;
            hold_left = LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on every input transaction and checks every result.
    always @(posedge i_clk) begin
        t_reading want;
        in_fire <= in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                expected_readings.push_back(compensate(in_ch.raw_temperature,
                                                       in_ch.raw_pressure));
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_readings.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result with nothing pending: temp %0d pres %0d",
                                 $realtime, out_ch.temperature_centi, out_ch.pressure_pa);
                end else begin
                    want = expected_readings.pop_front();
                    if (out_ch.temperature_centi !== want.temp ||
                        out_ch.pressure_pa !== want.pres) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: mismatch: temp %0d (want %0d) pres %0d (want %0d)",
                                     $realtime, out_ch.temperature_centi, want.temp,
                                     out_ch.pressure_pa, want.pres);
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        bpc_pkg::t_bpc_cal         cal;
        longint                    dt_cold;
        logic [bpc_pkg::RAW_W-1:0] ref_raw;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        cal_model     = '0;
        queued_total  = 0;
        results_seen  = 0;
        error_count   = 0;
        idle_cycles   = 0;
        stall_req     = 0;
        stall_ack     = 0;
        send_idle_pct = 14;
        recv_idle_pct = 68;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All calibration words still at their reset value of zero.
        queue_conversion('0, '0);
        queue_conversion(RAW_MAX, RAW_MAX);
        wait_drained();

        cal = {TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6};
        load_calibration(cal);
        ref_raw = {TYP_C5, 8'd0};
        // Smallest temperature difference that still reads -15.00 C.
        dt_cold = -((longint'(3500) << 23) / longint'(TYP_C6));
        queue_conversion('0, '0);
        queue_conversion(RAW_MAX, RAW_MAX);
        queue_conversion('0, RAW_MAX);
        queue_conversion(RAW_MAX, '0);
        queue_conversion(TYP_D2, TYP_D1);
        queue_conversion(ref_raw, TYP_D1);
        queue_conversion(ref_raw - 1'b1, TYP_D1);
        queue_conversion(ref_raw + dt_cold[bpc_pkg::RAW_W-1:0], TYP_D1);
        queue_conversion(ref_raw + dt_cold[bpc_pkg::RAW_W-1:0] - 1'b1, TYP_D1);
        queue_conversion(ref_raw + dt_cold[bpc_pkg::RAW_W-1:0] - 1'b1, '0);
        queue_conversion(ref_raw + dt_cold[bpc_pkg::RAW_W-1:0] - 1'b1, RAW_MAX);
        queue_conversion(24'hAAAAAA, 24'h555555);
        queue_conversion(24'h555555, 24'hAAAAAA);
        wait_drained();

        // Full-scale words drive pressure into both saturation limits.
        cal = '1;
        load_calibration(cal);
        queue_conversion('0, '0);
        queue_conversion('0, RAW_MAX);
        queue_conversion(RAW_MAX, RAW_MAX);
        queue_conversion(RAW_MAX, '0);
        wait_drained();

        for (int blk = 0; blk < 6; blk++) begin
            case (blk / 2)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (blk == 0)
                cal = {TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6};
            else if (blk == 1)
                cal = '0;
            else
                cal = {cal_word(), cal_word(), cal_word(),
                       cal_word(), cal_word(), cal_word()};
            load_calibration(cal);
            queue_random(BLOCK_ITEMS);
            if (blk == 4)
                stall_req++;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_readings.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bpc_pkg.sv
hdl/bpc_in_if.sv
hdl/bpc_out_if.sv
hdl/bpc_first_order.sv
hdl/bpc_second_order.sv
hdl/bpc_pressure.sv
hdl/barometric_pressure_compensation.sv
sim/barometric_pressure_compensation_test.sv
